FILE: rtl/core/hsv_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies.
package hsv_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int HUE_W = 16;
    localparam int SV_W  = 17;
    localparam int CH_W  = 8;

    // Hue in 1/16 degree: one turn and one sector
    localparam int HUE_TURN   = 5760;
    localparam int HUE_SECTOR = 960;
    localparam int SECTORS    = 6;

    localparam logic [SV_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } sector_t;

    // 1 - x in Q1.16, floored at zero
    function automatic logic [SV_W-1:0] one_minus(input logic [SV_W-1:0] x);
        logic [SV_W-1:0] res;
        res = (x >= ONE_Q16) ? '0 : (ONE_Q16 - x);
        return res;
    endfunction

    // floor(prod * 255 / 2^32), clamped at 255; prod is Q2.32
    function automatic logic [CH_W-1:0] to_channel(input logic [2*SV_W-1:0] prod);
        logic [2*SV_W+7:0] scaled;
        logic [9:0]        whole;
        scaled = {prod, 8'b0} - {8'b0, prod};
        whole  = scaled[2*SV_W+7:32];
        return (whole > 10'd255) ? 8'd255 : whole[7:0];
    endfunction

endpackage

FILE: rtl/core/hsv_hue_split.sv
// Hue front end: |hue| mod 360 degrees, sector select and fraction within the sector.
// Four register stages with a collapsing ready chain. Depends on hsv_pkg.
module hsv_hue_split #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [hsv_pkg::HUE_W-1:0] hue,
    input  logic [hsv_pkg::SV_W-1:0]      sat,
    input  logic [hsv_pkg::SV_W-1:0]      val,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsv_pkg::sector_t              sector,
    output logic [FRAC_BITS-1:0]          frac,
    output logic [hsv_pkg::SV_W-1:0]      sat_out,
    output logic [hsv_pkg::SV_W-1:0]      val_out
);

    // rem / 960 = (rem << (FRAC_BITS-6)) / 15 done by reciprocal multiply
    localparam int NUM_W  = FRAC_BITS + 4;
    localparam int SHIFT  = NUM_W + 4;
    localparam int RCP_W  = SHIFT - 3;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / 64'd15);

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic en1, en2, en3, en4;

    logic [hsv_pkg::SV_W-1:0] sat_reg [1:4];
    logic [hsv_pkg::SV_W-1:0] val_reg [1:4];

    logic [12:0]          red1_reg, red1_next;
    hsv_pkg::sector_t     sec2_reg, sec2_next, sec3_reg, sec4_reg;
    logic [9:0]           rem2_reg, rem2_next, rem3_reg;
    logic [PROD_W-1:0]    prod3_reg, prod3_next;
    logic [FRAC_BITS-1:0] frac4_reg, frac4_next;

    logic [15:0]          mag;
    logic [15:0]          turn_off;
    logic [12:0]          sec_off;
    logic [NUM_W-1:0]     num3;
    logic [FRAC_BITS-1:0] quo;
    logic [NUM_W-1:0]     resid;
    logic                 bump;
    logic [NUM_W-1:0]     resid_fixed;

    assign en4      = !vld4_reg || out_ready;
    assign en3      = !vld3_reg || en4;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    // stage 1: magnitude and turn reduction
    always_comb
    begin
        mag      = hue[15] ? (~hue + 16'd1) : hue;
        turn_off = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (mag >= 16'(k * hsv_pkg::HUE_TURN))
            begin
                turn_off = 16'(k * hsv_pkg::HUE_TURN);
            end
        end
        red1_next = 13'(mag - turn_off);
    end

    // stage 2: sector and remainder
    always_comb
    begin
        sec2_next = hsv_pkg::SEC_RED_YEL;
        sec_off   = '0;
        for (int k = 1; k < hsv_pkg::SECTORS; k++)
        begin
            if (red1_reg >= 13'(k * hsv_pkg::HUE_SECTOR))
            begin
                sec2_next = hsv_pkg::sector_t'(3'(k));
                sec_off   = 13'(k * hsv_pkg::HUE_SECTOR);
            end
        end
        rem2_next = 10'(red1_reg - sec_off);
    end

    // stage 3: reciprocal product
    assign prod3_next = PROD_W'({rem2_reg, {(FRAC_BITS-6){1'b0}}}) * PROD_W'(RECIP);

    // stage 4: estimate is low by at most one, fix with one compare
    always_comb
    begin
        num3        = {rem3_reg, {(FRAC_BITS-6){1'b0}}};
        quo         = prod3_reg[SHIFT+FRAC_BITS-1:SHIFT];
        resid       = num3 - ({quo, 4'b0} - {4'b0, quo});
        bump        = resid >= NUM_W'(15);
        resid_fixed = bump ? (resid - NUM_W'(15)) : resid;
        frac4_next  = quo + FRAC_BITS'(bump);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (en1) vld1_reg <= in_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
            if (en4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            red1_reg   <= red1_next;
            sat_reg[1] <= sat;
            val_reg[1] <= val;
        end
        if (en2)
        begin
            sec2_reg   <= sec2_next;
            rem2_reg   <= rem2_next;
            sat_reg[2] <= sat_reg[1];
            val_reg[2] <= val_reg[1];
        end
        if (en3)
        begin
            sec3_reg   <= sec2_reg;
            rem3_reg   <= rem2_reg;
            prod3_reg  <= prod3_next;
            sat_reg[3] <= sat_reg[2];
            val_reg[3] <= val_reg[2];
        end
        if (en4)
        begin
            sec4_reg   <= sec3_reg;
            frac4_reg  <= frac4_next;
            sat_reg[4] <= sat_reg[3];
            val_reg[4] <= val_reg[3];
        end
    end

    assign out_valid = vld4_reg;
    assign sector    = sec4_reg;
    assign frac      = frac4_reg;
    assign sat_out   = sat_reg[4];
    assign val_out   = val_reg[4];

`ifndef NO_ASSERTIONS
    a_turn_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld1_reg |-> red1_reg < 13'(hsv_pkg::HUE_TURN))
        else $error("hue not reduced below one turn");

    a_rem_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> rem2_reg < 10'(hsv_pkg::HUE_SECTOR))
        else $error("sector remainder out of range");

    a_recip_exact: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> resid_fixed < NUM_W'(15))
        else $error("reciprocal quotient off by more than one");
`endif

endmodule

FILE: rtl/core/hsv_to_rgb_convert.sv
// HSV to RGB converter: 8-stage pipeline, one pixel per clock while m_tready is high.
// Stages 1 to 4 are in hsv_hue_split, stages 5 to 8 are here.
// Throughput: one transfer per cycle unless m_tready stalls; a stall halts only the stages behind a full
// stage, so internal bubbles are squeezed out and nothing is dropped or repeated.
// Reset (rst_n low, async) clears every stage valid bit; payload is not reset.
// Depends on hsv_pkg and hsv_hue_split.
module hsv_to_rgb_convert #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hue_sixteenths[15:0], saturation[32:16], brightness[49:33], zero pad[55:50]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [23:0] m_tdata
);

    localparam int SVW = hsv_pkg::SV_W;

    logic                 hs_valid;
    logic                 hs_ready;
    hsv_pkg::sector_t     hs_sector;
    logic [FRAC_BITS-1:0] hs_frac;
    logic [SVW-1:0]       hs_sat;
    logic [SVW-1:0]       hs_val;

    hsv_hue_split #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hue_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue       (s_tdata[15:0]),
        .sat       (s_tdata[32:16]),
        .val       (s_tdata[49:33]),
        .out_valid (hs_valid),
        .out_ready (hs_ready),
        .sector    (hs_sector),
        .frac      (hs_frac),
        .sat_out   (hs_sat),
        .val_out   (hs_val)
    );

    logic vld5_reg, vld6_reg, vld7_reg, vld8_reg;
    logic en5, en6, en7, en8;

    hsv_pkg::sector_t      sec5_reg, sec6_reg, sec7_reg, out_sec;
    logic [SVW-1:0]        val5_reg, val6_reg, val7_reg;
    logic [SVW+FRAC_BITS-1:0] sf5_reg;
    logic [SVW+FRAC_BITS:0]   sfc5_reg;
    logic [SVW-1:0]        pf5_reg, pf6_reg, qf6_reg, tf6_reg;
    logic [2*SVW-1:0]      pp7_reg, qp7_reg, tp7_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic [7:0]            red_next, green_next, blue_next;
    logic [7:0]            vc, pc, qc, tc;
    logic [FRAC_BITS:0]    frac_comp;

    assign en8      = !vld8_reg || m_tready;
    assign en7      = !vld7_reg || en8;
    assign en6      = !vld6_reg || en7;
    assign en5      = !vld5_reg || en6;
    assign hs_ready = en5;

    assign frac_comp = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, hs_frac};

    always_comb
    begin
        out_sec = sec7_reg;
        vc = hsv_pkg::to_channel({1'b0, val7_reg, 16'b0});
        pc = hsv_pkg::to_channel(pp7_reg);
        qc = hsv_pkg::to_channel(qp7_reg);
        tc = hsv_pkg::to_channel(tp7_reg);
        case (out_sec)
            hsv_pkg::SEC_RED_YEL:
            begin
                red_next = vc; green_next = tc; blue_next = pc;
            end
            hsv_pkg::SEC_YEL_GRN:
            begin
                red_next = qc; green_next = vc; blue_next = pc;
            end
            hsv_pkg::SEC_GRN_CYN:
            begin
                red_next = pc; green_next = vc; blue_next = tc;
            end
            hsv_pkg::SEC_CYN_BLU:
            begin
                red_next = pc; green_next = qc; blue_next = vc;
            end
            hsv_pkg::SEC_BLU_MAG:
            begin
                red_next = tc; green_next = pc; blue_next = vc;
            end
            default:
            begin
                red_next = vc; green_next = pc; blue_next = qc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
        end
        else
        begin
            if (en5) vld5_reg <= hs_valid;
            if (en6) vld6_reg <= vld5_reg;
            if (en7) vld7_reg <= vld6_reg;
            if (en8) vld8_reg <= vld7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // S*f, S*(1-f) and 1 - S
        if (en5)
        begin
            sec5_reg <= hs_sector;
            val5_reg <= hs_val;
            sf5_reg  <= (SVW+FRAC_BITS)'(hs_sat) * (SVW+FRAC_BITS)'(hs_frac);
            sfc5_reg <= (SVW+FRAC_BITS+1)'(hs_sat) * (SVW+FRAC_BITS+1)'(frac_comp);
            pf5_reg  <= hsv_pkg::one_minus(hs_sat);
        end
        // truncate to Q1.16 and form the (1 - x) factors
        if (en6)
        begin
            sec6_reg <= sec5_reg;
            val6_reg <= val5_reg;
            pf6_reg  <= pf5_reg;
            qf6_reg  <= hsv_pkg::one_minus(sf5_reg[FRAC_BITS+SVW-1:FRAC_BITS]);
            tf6_reg  <= hsv_pkg::one_minus(sfc5_reg[FRAC_BITS+SVW-1:FRAC_BITS]);
        end
        // V times each factor, Q2.32
        if (en7)
        begin
            sec7_reg <= sec6_reg;
            val7_reg <= val6_reg;
            pp7_reg  <= (2*SVW)'(val6_reg) * (2*SVW)'(pf6_reg);
            qp7_reg  <= (2*SVW)'(val6_reg) * (2*SVW)'(qf6_reg);
            tp7_reg  <= (2*SVW)'(val6_reg) * (2*SVW)'(tf6_reg);
        end
        if (en8)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = vld8_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

`ifndef NO_ASSERTIONS
    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld6_reg |-> (pf6_reg <= hsv_pkg::ONE_Q16) && (qf6_reg <= hsv_pkg::ONE_Q16)
                     && (tf6_reg <= hsv_pkg::ONE_Q16))
        else $error("channel factor above 1.0");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld7_reg && !en7) |=> (vld7_reg && $stable(pp7_reg) && $stable(sec7_reg)))
        else $error("stalled stage lost or changed its pixel");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !vld7_reg) |=> !m_tvalid)
        else $error("output valid without a pixel behind it");
`endif

endmodule

FILE: test/hsv_to_rgb_convert_test.sv
// Self-checking bench for hsv_to_rgb_convert: random and corner HSV pixels are streamed in,
// and every RGB transfer is compared against a behavioral predictor kept in this file.
// Depends on hsv_pkg and the hsv_to_rgb_convert RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_convert_test;

    localparam int HUE_W      = hsv_pkg::HUE_W;
    localparam int SV_W       = hsv_pkg::SV_W;
    localparam int CH_W       = hsv_pkg::CH_W;
    localparam int FRAC       = hsv_pkg::FRAC_BITS_DEFAULT;
    localparam int N_RANDOM   = 1850;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 24;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [SV_W-1:0]         sat;
        logic [SV_W-1:0]         val;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    hsv_pixel_t pixel_queue[$];
    rgb_pixel_t expected_rgb[$];

    int  error_count  = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  send_wait    = 0;
    int  recv_wait    = 0;
    bit  send_burst   = 1'b0;
    bit  recv_burst   = 1'b1;
    bit  hold_off     = 1'b0;

    hsv_to_rgb_convert #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // (1 - x) in Q1.16, never below zero
    function automatic logic [SV_W-1:0] inverse_q16(input logic [63:0] x);
        logic [SV_W-1:0] res;
        res = (x >= 64'(hsv_pkg::ONE_Q16)) ? '0 : SV_W'(64'(hsv_pkg::ONE_Q16) - x);
        return res;
    endfunction

    // floor(v * factor * 255 / 2^32), clamped at full scale
    function automatic logic [CH_W-1:0] channel_level(input logic [SV_W-1:0] v,
                                                      input logic [SV_W-1:0] factor);
        logic [63:0] level;
        level = ((64'(v) * 64'(factor)) * 64'd255) >> 32;
        return (level > 64'd255) ? 8'd255 : level[CH_W-1:0];
    endfunction

    function automatic rgb_pixel_t predict_rgb(input hsv_pixel_t px);
        int               hue_int;
        int               hue_mag;
        int               turn_pos;
        hsv_pkg::sector_t sec;
        logic [63:0]      rem;
        logic [63:0]      frac;
        logic [63:0]      s_frac;
        logic [63:0]      s_cofrac;
        logic [CH_W-1:0]  v_ch, p_ch, q_ch, t_ch;
        rgb_pixel_t       res;
        hue_int  = px.hue;
        hue_mag  = (hue_int < 0) ? -hue_int : hue_int;
        turn_pos = hue_mag % hsv_pkg::HUE_TURN;
        sec      = hsv_pkg::sector_t'(turn_pos / hsv_pkg::HUE_SECTOR);
        rem      = 64'(turn_pos % hsv_pkg::HUE_SECTOR);
        frac     = (rem << FRAC) / 64'(hsv_pkg::HUE_SECTOR);
        s_frac   = (64'(px.sat) * frac) >> FRAC;
        s_cofrac = (64'(px.sat) * ((64'd1 << FRAC) - frac)) >> FRAC;
        v_ch = channel_level(px.val, hsv_pkg::ONE_Q16);
        p_ch = channel_level(px.val, inverse_q16(64'(px.sat)));
        q_ch = channel_level(px.val, inverse_q16(s_frac));
        t_ch = channel_level(px.val, inverse_q16(s_cofrac));
        case (sec)
            hsv_pkg::SEC_RED_YEL: res = '{v_ch, t_ch, p_ch};
            hsv_pkg::SEC_YEL_GRN: res = '{q_ch, v_ch, p_ch};
            hsv_pkg::SEC_GRN_CYN: res = '{p_ch, v_ch, t_ch};
            hsv_pkg::SEC_CYN_BLU: res = '{p_ch, q_ch, v_ch};
            hsv_pkg::SEC_BLU_MAG: res = '{t_ch, p_ch, v_ch};
            default:              res = '{v_ch, p_ch, q_ch};
        endcase
        return res;
    endfunction

    function automatic int next_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    // mostly legal Q1.16, some exact endpoints, some over-range codes
    function automatic logic [SV_W-1:0] random_q16();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return SV_W'($urandom_range(0, 65536));
        else if (pick < 80)
            return ($urandom_range(0, 1) == 0) ? '0 : hsv_pkg::ONE_Q16;
        else
            return SV_W'($urandom_range(0, 131071));
    endfunction

    function automatic logic signed [HUE_W-1:0] random_hue();
        int edge_pt;
        if ($urandom_range(0, 3) == 0)
        begin
            // land next to a sector or turn boundary, either sign
            edge_pt = hsv_pkg::HUE_SECTOR * int'($urandom_range(0, 34))
                      + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 0)
                edge_pt = -edge_pt;
            return HUE_W'(edge_pt);
        end
        return HUE_W'($urandom_range(0, 65535));
    endfunction

    task automatic add_pixel(input int hue, input int sat, input int val);
        hsv_pixel_t px;
        px.hue = HUE_W'(hue);
        px.sat = SV_W'(sat);
        px.val = SV_W'(val);
        pixel_queue.push_back(px);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // stimulus and end of run
    initial
    begin
        hsv_pixel_t px;
        // gray cases
        add_pixel(0, 0, 65536);
        add_pixel(0, 0, 0);
        add_pixel(0, 0, 131071);
        add_pixel(0, 0, 32768);
        add_pixel(32767, 0, 1);
        // one hue per sector, fully saturated
        add_pixel(0, 65536, 65536);
        add_pixel(960, 65536, 65536);
        add_pixel(1920, 65536, 65536);
        add_pixel(2880, 65536, 65536);
        add_pixel(3840, 65536, 65536);
        add_pixel(4800, 65536, 65536);
        // sector and turn edges, negative and extreme hue
        add_pixel(959, 65536, 65536);
        add_pixel(5759, 65536, 65536);
        add_pixel(5760, 65536, 65536);
        add_pixel(-32768, 65536, 65536);
        add_pixel(32767, 65536, 65536);
        add_pixel(-1, 65536, 65536);
        add_pixel(-960, 65536, 65536);
        add_pixel(-5760, 40000, 50000);
        // saturation past 1.0 floors the factors, plus one case just under 1.0
        add_pixel(480, 131071, 65536);
        add_pixel(3000, 70000, 65536);
        add_pixel(1234, 65535, 65535);
        add_pixel(-32768, 131071, 131071);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            px.hue = random_hue();
            px.sat = random_q16();
            px.val = random_q16();
            pixel_queue.push_back(px);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("hsv_to_rgb_convert verification clean");
        else
            $display("hsv_to_rgb_convert verification failed");
        $finish;
    end

    // long output stall once the stream is running, so the pipe backs up into s_tready
    initial
    begin
        while (results_seen < 700)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_rgb.push_back(predict_rgb(pixel_queue.pop_front()));
                if ($urandom_range(0, 49) == 0)
                    send_burst = !send_burst;
                send_wait = next_gap(send_burst);
            end
            if (s_tvalid && !s_tready)
            begin
                // transfer still pending, hold data
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pixel_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pixel_queue[0].val, pixel_queue[0].sat, pixel_queue[0].hue};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor and ready pattern
    always @(posedge clk)
    begin
        rgb_pixel_t want;
        rgb_pixel_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
                if (expected_rgb.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                                              got.red, got.green, got.blue));
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    if (got.red != want.red)
                        report_mismatch($sformatf("red got %0d want %0d",
                                                  got.red, want.red));
                    if (got.green != want.green)
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  got.green, want.green));
                    if (got.blue != want.blue)
                        report_mismatch($sformatf("blue got %0d want %0d",
                                                  got.blue, want.blue));
                end
                if ($urandom_range(0, 49) == 0)
                    recv_burst = !recv_burst;
                recv_wait = next_gap(recv_burst);
            end
            if (hold_off)
            begin
                m_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("hsv_to_rgb_convert verification failed");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/core/hsv_pkg.sv
rtl/core/hsv_hue_split.sv
rtl/core/hsv_to_rgb_convert.sv
test/hsv_to_rgb_convert_test.sv
